// ===== rtl/core/bmhq_pkg.sv =====
// ----------------------------------------------------------------------------
// Binary min-heap queue package
// Sizes, item types, operation and status codes, and controller states
// shared by the heap queue and its testbench.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    // Number of heap slots and stored key width.
    localparam int CAPACITY = 256;
    localparam int KEY_BITS = 32;

    // Slot address, entry count and child index widths.
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int LIDX_W = ADDR_W + 2;

    // Field widths of the items on the ports.
    localparam int PORT_KEY_W = 32;
    localparam int TOTAL_W    = 9;

    typedef logic [ADDR_W-1:0]            t_addr;
    typedef logic [CNT_W-1:0]             t_count;
    typedef logic [LIDX_W-1:0]            t_lidx;
    typedef logic signed [KEY_BITS-1:0]   t_key;
    typedef logic signed [PORT_KEY_W-1:0] t_port_key;

    // Requested operation.
    typedef enum logic {
        MODE_PUSH = 1'b0,
        MODE_POP  = 1'b1
    } t_mode;

    // Result status.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Input item.
    typedef struct packed {
        t_mode     mode;
        t_port_key key_in;
    } t_in;

    // Result item.
    typedef struct packed {
        t_port_key            popped_key;
        t_port_key            top_key;
        logic [TOTAL_W-1:0]   entry_total;
        t_status              status;
    } t_out;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_POP_LD,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_FIN
    } t_state;

endpackage

// ===== rtl/core/bmhq_ram.sv =====
// ----------------------------------------------------------------------------
// Heap slot memory
// Simple dual-port synchronous RAM: one write port and one read port with
// the read data registered, so a read returns its data in the next cycle.
// ----------------------------------------------------------------------------
module bmhq_ram #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/binary_min_heap_queue.sv =====
// ----------------------------------------------------------------------------
// Binary min-heap queue
// Array-based min-heap of signed keys held in one slot memory. A push sifts
// the new key up from the first free slot; a pop returns the root and sifts
// the last key down from the root. Each item yields one result item.
//
//   Channel | Ports                                   | Item
//   --------+-----------------------------------------+------------------
//   input   | i_in_valid, o_in_ready, i_in_item       | mode, key_in
//   output  | o_out_valid, i_out_ready, o_out_item    | popped_key,
//           |                                         | top_key,
//           |                                         | entry_total, status
//
// A refused push, an empty pop or a pop of the last key goes straight from
// idle to the final state; other items first sift their key through the heap.
// Input is taken again in the cycle after the result is loaded, even while that
// result still waits in the output register; a second result holds the
// controller in its final state until the receiver takes the first.
// Reset is synchronous and leaves the heap empty; no clearing pass is needed.
// ----------------------------------------------------------------------------
module binary_min_heap_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  bmhq_pkg::t_in   i_in_item,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output bmhq_pkg::t_out  o_out_item
);

    bmhq_pkg::t_state  r_state, n_state;
    bmhq_pkg::t_count  r_count, n_count;
    bmhq_pkg::t_addr   r_idx, n_idx;
    bmhq_pkg::t_addr   r_par, n_par;
    bmhq_pkg::t_key    r_key, n_key;
    bmhq_pkg::t_key    r_lkey, n_lkey;
    logic              r_hasr, n_hasr;
    bmhq_pkg::t_key    r_top;
    bmhq_pkg::t_key    r_popped, n_popped;
    bmhq_pkg::t_status r_status, n_status;
    logic              r_ovalid, n_ovalid;
    bmhq_pkg::t_out    r_out, n_out;

    logic              mem_we;
    bmhq_pkg::t_addr   mem_waddr;
    bmhq_pkg::t_key    mem_wdata;
    logic              mem_re;
    bmhq_pkg::t_addr   mem_raddr;
    bmhq_pkg::t_key    mem_rdata;

    logic              in_acc;
    logic              fin_load;
    bmhq_pkg::t_lidx   lidx;
    bmhq_pkg::t_lidx   ridx;
    bmhq_pkg::t_lidx   cnt_ext;
    bmhq_pkg::t_addr   par_idx;
    bmhq_pkg::t_key    child_key;
    bmhq_pkg::t_addr   child_idx;

    // Slot memory.
    bmhq_ram #(
        .DEPTH (bmhq_pkg::CAPACITY),
        .WIDTH (bmhq_pkg::KEY_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Handshakes.
    assign o_in_ready  = (r_state == bmhq_pkg::S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign fin_load    = (r_state == bmhq_pkg::S_FIN) && (!r_ovalid || i_out_ready);
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

    // Tree navigation around the current slot.
    assign lidx    = bmhq_pkg::t_lidx'({r_idx, 1'b1});
    assign ridx    = lidx + bmhq_pkg::t_lidx'(1);
    assign cnt_ext = bmhq_pkg::t_lidx'(r_count);
    assign par_idx = (r_idx - bmhq_pkg::t_addr'(1)) >> 1;

    // Smaller child; the left child wins a tie.
    always_comb begin
        if (r_hasr && (mem_rdata < r_lkey)) begin
            child_key = mem_rdata;
            child_idx = ridx[bmhq_pkg::ADDR_W-1:0];
        end else begin
            child_key = r_lkey;
            child_idx = lidx[bmhq_pkg::ADDR_W-1:0];
        end
    end

    // Next state and memory control.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_par     = r_par;
        n_key     = r_key;
        n_lkey    = r_lkey;
        n_hasr    = r_hasr;
        n_popped  = r_popped;
        n_status  = r_status;
        n_ovalid  = r_ovalid;
        n_out     = r_out;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = r_key;
        mem_re    = 1'b0;
        mem_raddr = par_idx;

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            bmhq_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_popped = '0;
                    n_status = bmhq_pkg::ST_OK;
                    n_key    = bmhq_pkg::t_key'(i_in_item.key_in);
                    if (i_in_item.mode == bmhq_pkg::MODE_PUSH) begin
                        if (r_count == bmhq_pkg::t_count'(bmhq_pkg::CAPACITY)) begin
                            n_status = bmhq_pkg::ST_FULL;
                            n_state  = bmhq_pkg::S_FIN;
                        end else begin
                            n_idx   = r_count[bmhq_pkg::ADDR_W-1:0];
                            n_count = r_count + bmhq_pkg::t_count'(1);
                            n_state = bmhq_pkg::S_UP_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = bmhq_pkg::ST_EMPTY;
                            n_state  = bmhq_pkg::S_FIN;
                        end else begin
                            n_popped  = r_top;
                            n_count   = r_count - bmhq_pkg::t_count'(1);
                            // Fetch the last key, which moves to the root.
                            mem_re    = 1'b1;
                            mem_raddr = n_count[bmhq_pkg::ADDR_W-1:0];
                            n_state   = (n_count == '0) ? bmhq_pkg::S_FIN
                                                        : bmhq_pkg::S_POP_LD;
                        end
                    end
                end
            end

            // Sift up: read the parent, or settle at the root.
            bmhq_pkg::S_UP_RD: begin
                if (r_idx == '0) begin
                    mem_we  = 1'b1;
                    n_state = bmhq_pkg::S_FIN;
                end else begin
                    mem_re  = 1'b1;
                    n_par   = par_idx;
                    n_state = bmhq_pkg::S_UP_CMP;
                end
            end

            // Sift up: move the parent down into the hole while the key is smaller.
            bmhq_pkg::S_UP_CMP: begin
                mem_we = 1'b1;
                if (r_key < mem_rdata) begin
                    mem_wdata = mem_rdata;
                    n_idx     = r_par;
                    n_state   = bmhq_pkg::S_UP_RD;
                end else begin
                    n_state = bmhq_pkg::S_FIN;
                end
            end

            // Pop: the last key becomes the sinking key, starting at the root.
            bmhq_pkg::S_POP_LD: begin
                n_key   = mem_rdata;
                n_idx   = '0;
                n_state = bmhq_pkg::S_DN_RDL;
            end

            // Sift down: read the left child, or settle at a leaf.
            bmhq_pkg::S_DN_RDL: begin
                if (lidx >= cnt_ext) begin
                    mem_we  = 1'b1;
                    n_state = bmhq_pkg::S_FIN;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = lidx[bmhq_pkg::ADDR_W-1:0];
                    n_state   = bmhq_pkg::S_DN_RDR;
                end
            end

            // Sift down: keep the left child and read the right one if present.
            bmhq_pkg::S_DN_RDR: begin
                n_lkey    = mem_rdata;
                n_hasr    = (ridx < cnt_ext);
                mem_re    = (ridx < cnt_ext);
                mem_raddr = ridx[bmhq_pkg::ADDR_W-1:0];
                n_state   = bmhq_pkg::S_DN_CMP;
            end

            // Sift down: move the smaller child up while it is smaller than the key.
            bmhq_pkg::S_DN_CMP: begin
                mem_we = 1'b1;
                if (child_key < r_key) begin
                    mem_wdata = child_key;
                    n_idx     = child_idx;
                    n_state   = bmhq_pkg::S_DN_RDL;
                end else begin
                    n_state = bmhq_pkg::S_FIN;
                end
            end

            // Result goes out once the output register is free.
            bmhq_pkg::S_FIN: begin
                if (fin_load) begin
                    n_out.popped_key  = bmhq_pkg::t_port_key'(r_popped);
                    n_out.top_key     = (r_count == '0) ? '0
                                        : bmhq_pkg::t_port_key'(r_top);
                    n_out.entry_total = bmhq_pkg::TOTAL_W'(r_count);
                    n_out.status      = r_status;
                    n_ovalid          = 1'b1;
                    n_state           = bmhq_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = bmhq_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bmhq_pkg::S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    // Working and result registers.
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_par    <= n_par;
        r_key    <= n_key;
        r_lkey   <= n_lkey;
        r_hasr   <= n_hasr;
        r_popped <= n_popped;
        r_status <= n_status;
        r_out    <= n_out;
    end

    // Copy of the root slot, kept current on every write to slot zero.
    always_ff @(posedge i_clk) begin
        if (mem_we && (mem_waddr == '0)) begin
            r_top <= mem_wdata;
        end
    end

`ifndef SYNTHESIS
    // The schedule never reads and writes the same slot in one cycle.
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we && mem_re |-> mem_waddr != mem_raddr)
        else $error("slot read and written in the same cycle");

    // The entry count stays within the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bmhq_pkg::t_count'(bmhq_pkg::CAPACITY))
        else $error("entry count above capacity");

    // The sift-up compare state and the pop load state always follow a read issued in the cycle before.
    a_cmp_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bmhq_pkg::S_UP_CMP || r_state == bmhq_pkg::S_POP_LD)
        |-> $past(mem_re))
        else $error("compare without a preceding read");

    // An empty heap reports a zero minimum.
    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.entry_total == '0) |-> o_out_item.top_key == '0)
        else $error("nonzero minimum reported for an empty heap");

    // A refused push is reported only with the heap at capacity.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == bmhq_pkg::ST_FULL)
        |-> o_out_item.entry_total == bmhq_pkg::TOTAL_W'(bmhq_pkg::CAPACITY))
        else $error("full status below capacity");
`endif

endmodule

// ===== tb/binary_min_heap_queue_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Binary min-heap queue testbench
// Drives push and pop items through the valid/ready input channel and checks
// each result item against its directed-table expectation or a heap predictor,
// kept in step with accepted items. A short table of directed items comes
// first, then random traffic that fills the heap to capacity, drains it to
// empty, and mixes the two with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_tb;

    // Clock, reset and ports of the block.
    logic            i_clk       = 1'b0;
    logic            i_rst_n     = 1'b0;
    logic            i_in_valid  = 1'b0;
    logic            o_in_ready;
    bmhq_pkg::t_in   i_in_item   = '0;
    logic            o_out_valid;
    logic            i_out_ready = 1'b0;
    bmhq_pkg::t_out  o_out_item;

    // One row of the directed table.
    typedef struct {
        bmhq_pkg::t_mode     mode;
        bmhq_pkg::t_port_key key;
        bit                  typed;
        bmhq_pkg::t_out      want;
    } t_row;

    // Heap predictor state.
    bmhq_pkg::t_key heap_slots [bmhq_pkg::CAPACITY];
    int unsigned    heap_size = 0;

    // Results still to arrive, oldest first.
    bmhq_pkg::t_out awaited_results [$];
    t_row           directed_rows [$];

    int  mismatch_count = 0;
    bit  random_phase   = 1'b0;
    int  burst_left     = 0;

    binary_min_heap_queue DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always #1 i_clk = ~i_clk;

    // Apply one item to the predicted heap and return the result it causes.
    function automatic bmhq_pkg::t_out heap_apply(bmhq_pkg::t_in it);
        bmhq_pkg::t_out res;
        bmhq_pkg::t_key tmp;
        int unsigned    i;
        int unsigned    p;
        int unsigned    l;
        int unsigned    r;
        int unsigned    best;
        res = '0;
        res.status = bmhq_pkg::ST_OK;
        if (it.mode == bmhq_pkg::MODE_PUSH) begin
            if (heap_size >= bmhq_pkg::CAPACITY) begin
                res.status = bmhq_pkg::ST_FULL;
            end else begin
                // Sift up while strictly smaller than the parent.
                i = heap_size;
                heap_slots[i] = bmhq_pkg::t_key'(it.key_in);
                while (i > 0) begin
                    p = (i - 1) / 2;
                    if (heap_slots[i] < heap_slots[p]) begin
                        tmp = heap_slots[i];
                        heap_slots[i] = heap_slots[p];
                        heap_slots[p] = tmp;
                        i = p;
                    end else begin
                        break;
                    end
                end
                heap_size++;
            end
        end else begin
            if (heap_size == 0) begin
                res.status = bmhq_pkg::ST_EMPTY;
            end else begin
                res.popped_key = bmhq_pkg::t_port_key'(heap_slots[0]);
                heap_size--;
                if (heap_size > 0) begin
                    // Sift down toward the smaller child; the left child wins a tie.
                    heap_slots[0] = heap_slots[heap_size];
                    i = 0;
                    while (i < heap_size) begin
                        best = i;
                        l = 2 * i + 1;
                        r = 2 * i + 2;
                        if (l < heap_size && heap_slots[l] < heap_slots[best])
                            best = l;
                        if (r < heap_size && heap_slots[r] < heap_slots[best])
                            best = r;
                        if (best == i)
                            break;
                        tmp = heap_slots[i];
                        heap_slots[i] = heap_slots[best];
                        heap_slots[best] = tmp;
                        i = best;
                    end
                end
            end
        end
        res.top_key     = (heap_size > 0) ? bmhq_pkg::t_port_key'(heap_slots[0]) : '0;
        res.entry_total = bmhq_pkg::TOTAL_W'(heap_size);
        return res;
    endfunction

    // Random key: mostly full range, often a narrow band to force equal keys.
    function automatic bmhq_pkg::t_port_key pick_key();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: pick_key = 32'sh8000_0000;
                    1: pick_key = 32'sh7fff_ffff;
                    2: pick_key = 32'sd0;
                    default: pick_key = -32'sd1;
                endcase
            end
            1, 2, 3: pick_key = bmhq_pkg::t_port_key'($urandom_range(0, 16)) - 32'sd8;
            default: pick_key = bmhq_pkg::t_port_key'($urandom);
        endcase
    endfunction

    task automatic add_row(input bmhq_pkg::t_mode m, input bmhq_pkg::t_port_key k,
                           input bit typed,
                           input bmhq_pkg::t_port_key pk, input bmhq_pkg::t_port_key tk,
                           input int total, input bmhq_pkg::t_status st);
        t_row row;
        row.mode  = m;
        row.key   = k;
        row.typed = typed;
        row.want.popped_key  = pk;
        row.want.top_key     = tk;
        row.want.entry_total = bmhq_pkg::TOTAL_W'(total);
        row.want.status      = st;
        directed_rows.push_back(row);
    endtask

    // Offer one item and hold it until accepted; then record its result.
    task automatic send_item(input bmhq_pkg::t_in it, input bit typed,
                             input bmhq_pkg::t_out want);
        bmhq_pkg::t_out pred;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        pred = heap_apply(it);
        awaited_results.push_back(typed ? want : pred);
    endtask

    task automatic send_random(input bmhq_pkg::t_mode m);
        bmhq_pkg::t_in it;
        it.mode   = m;
        it.key_in = pick_key();
        send_item(it, 1'b0, '0);
    endtask

    // Sender pacing: bursts of random length with idle gaps between them.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 20);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(0, 30);
        end
    endtask

    // Stop offering items until every expected result has come back.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Mixed traffic with the given percentage of pushes.
    task automatic mixed_traffic(input int count, input int push_pct);
        repeat (count) begin
            send_random(($urandom_range(0, 99) < push_pct) ? bmhq_pkg::MODE_PUSH
                                                           : bmhq_pkg::MODE_POP);
            pace_sender();
        end
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
        mismatch_count++;
    endtask

    // Compare every accepted result item with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        bmhq_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result item %h", $realtime, o_out_item);
                mismatch_count++;
            end else begin
                want = awaited_results.pop_front();
                if (o_out_item.popped_key !== want.popped_key)
                    report_field("popped_key", want.popped_key, o_out_item.popped_key);
                if (o_out_item.top_key !== want.top_key)
                    report_field("top_key", want.top_key, o_out_item.top_key);
                if (o_out_item.entry_total !== want.entry_total)
                    report_field("entry_total", 32'(want.entry_total),
                                 32'(o_out_item.entry_total));
                if (o_out_item.status !== want.status)
                    report_field("status", 32'(want.status), 32'(o_out_item.status));
            end
        end
    end

    // Receiver: changing stall patterns, plus one long hold-off during random traffic.
    initial begin : receiver
        int  pattern;
        int  pattern_left;
        int  hold_left;
        int  since_random;
        int  phase_cnt;
        bit  hold_done;
        pattern      = 0;
        pattern_left = 0;
        hold_left    = 0;
        since_random = 0;
        phase_cnt    = 0;
        hold_done    = 1'b0;
        forever begin
            @(negedge i_clk);
            phase_cnt++;
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                if (random_phase && !hold_done) begin
                    since_random++;
                    if (since_random == 800) begin
                        hold_left = 400;
                        hold_done = 1'b1;
                    end
                end
                if (pattern_left == 0) begin
                    pattern      = $urandom_range(0, 3);
                    pattern_left = $urandom_range(20, 200);
                end
                pattern_left--;
                case (pattern)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= 1'($urandom_range(0, 1));
                    2: i_out_ready <= ($urandom_range(0, 7) != 0);
                    default: i_out_ready <= (phase_cnt % 16) >= 5;
                endcase
            end
        end
    end

    // Stimulus: directed table, then random phases.
    initial begin : stimulus
        t_row          row;
        bmhq_pkg::t_in it;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows: extremes, equal keys, empty pops.
        add_row(bmhq_pkg::MODE_POP,  32'sd0,         1, 32'sd0, 32'sd0, 0,
                bmhq_pkg::ST_EMPTY);
        add_row(bmhq_pkg::MODE_PUSH, 32'sh7fff_ffff, 1, 32'sd0, 32'sh7fff_ffff, 1,
                bmhq_pkg::ST_OK);
        add_row(bmhq_pkg::MODE_PUSH, 32'sh8000_0000, 1, 32'sd0, 32'sh8000_0000, 2,
                bmhq_pkg::ST_OK);
        add_row(bmhq_pkg::MODE_PUSH, 32'sd0,         1, 32'sd0, 32'sh8000_0000, 3,
                bmhq_pkg::ST_OK);
        add_row(bmhq_pkg::MODE_PUSH, -32'sd1,        0, 32'sd0, 32'sd0, 0,
                bmhq_pkg::ST_OK);
        add_row(bmhq_pkg::MODE_PUSH, 32'sh8000_0000, 1, 32'sd0, 32'sh8000_0000, 5,
                bmhq_pkg::ST_OK);
        add_row(bmhq_pkg::MODE_PUSH, 32'sd1,         0, 32'sd0, 32'sd0, 0,
                bmhq_pkg::ST_OK);
        add_row(bmhq_pkg::MODE_PUSH, 32'sh7fff_ffff, 0, 32'sd0, 32'sd0, 0,
                bmhq_pkg::ST_OK);
        add_row(bmhq_pkg::MODE_PUSH, -32'sd1,        0, 32'sd0, 32'sd0, 0,
                bmhq_pkg::ST_OK);
        add_row(bmhq_pkg::MODE_POP,  32'sh1234_5678, 1, 32'sh8000_0000,
                32'sh8000_0000, 7, bmhq_pkg::ST_OK);
        add_row(bmhq_pkg::MODE_POP,  32'sd0,         1, 32'sh8000_0000, -32'sd1, 6,
                bmhq_pkg::ST_OK);
        repeat (6) add_row(bmhq_pkg::MODE_POP, 32'sd0, 0, 32'sd0, 32'sd0, 0,
                           bmhq_pkg::ST_OK);
        add_row(bmhq_pkg::MODE_POP,  -32'sd1,        1, 32'sd0, 32'sd0, 0,
                bmhq_pkg::ST_EMPTY);
        add_row(bmhq_pkg::MODE_PUSH, 32'sh5555_aaaa, 0, 32'sd0, 32'sd0, 0,
                bmhq_pkg::ST_OK);
        add_row(bmhq_pkg::MODE_PUSH, 32'shaaaa_5555, 0, 32'sd0, 32'sd0, 0,
                bmhq_pkg::ST_OK);
        add_row(bmhq_pkg::MODE_POP,  32'sd0,         0, 32'sd0, 32'sd0, 0,
                bmhq_pkg::ST_OK);
        add_row(bmhq_pkg::MODE_POP,  32'sd0,         0, 32'sd0, 32'sd0, 0,
                bmhq_pkg::ST_OK);

        foreach (directed_rows[n]) begin
            row       = directed_rows[n];
            it.mode   = row.mode;
            it.key_in = row.key;
            send_item(it, row.typed, row.want);
        end
        drain_results();

        // Random mix, mostly pushes so the heap grows deep.
        random_phase = 1'b1;
        mixed_traffic(350, 60);
        drain_results();

        // Fill to capacity, knock on the full heap, then drain past empty.
        while (heap_size < bmhq_pkg::CAPACITY) begin
            send_random(($urandom_range(0, 9) == 0) ? bmhq_pkg::MODE_POP
                                                    : bmhq_pkg::MODE_PUSH);
            pace_sender();
        end
        repeat (8) begin
            send_random(bmhq_pkg::MODE_PUSH);
            pace_sender();
        end
        repeat (10) begin
            send_random(bmhq_pkg::MODE_POP);
            send_random(bmhq_pkg::MODE_PUSH);
            send_random(bmhq_pkg::MODE_PUSH);
            pace_sender();
        end
        while (heap_size > 0) begin
            send_random(($urandom_range(0, 9) == 0) ? bmhq_pkg::MODE_PUSH
                                                    : bmhq_pkg::MODE_POP);
            pace_sender();
        end
        repeat (4) send_random(bmhq_pkg::MODE_POP);
        drain_results();

        // Balanced mix that hovers near empty.
        mixed_traffic(300, 50);
        drain_results();

        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin : watchdog
        #1000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
